FILE: hw/rtl/sorted_priority_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue unit
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");
`define SPQ_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed: label");
`else
`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue unit.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned CountW       = 5;
  localparam int unsigned FqDepth      = 2;

  typedef enum logic [1:0] {
    REQ_PUSH      = 2'd0,
    REQ_POP_HEAD  = 2'd1,
    REQ_POP_EXACT = 2'd2,
    REQ_POP_GE    = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] priority_key;
    logic [7:0] item_message;
  } req_t;

  typedef struct packed {
    logic                done_res;
    logic                full_reject;
    logic [7:0]          out_message;
    logic [7:0]          out_priority;
    logic [CountW-1:0]   entry_count;
  } rsp_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic       is_push;
    logic       is_head;
    logic       exact;
    logic [7:0] key;
    logic [7:0] msg;
  } cmd_t;

endpackage

FILE: hw/rtl/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic            valid;
  logic            ready;
  spq_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface spq_rsp_if;
  logic            valid;
  logic            ready;
  spq_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/spq_front.sv
// ----------------------------------------------------------------------------
// spq_front
// Decode requests and queue them in a short command FIFO.
// ----------------------------------------------------------------------------
module spq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spq_pkg::req_t      in_req_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output spq_pkg::cmd_t      cmd_o
);

  spq_pkg::cmd_t fifo_q [spq_pkg::FqDepth];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  spq_pkg::cmd_t dec;

  always_comb begin
    dec.is_push = 1'b0;
    dec.is_head = 1'b0;
    dec.exact   = 1'b0;
    dec.key     = in_req_i.priority_key;
    dec.msg     = in_req_i.item_message;
    unique case (spq_pkg::req_e'(in_req_i.req_type))
      spq_pkg::REQ_PUSH:      dec.is_push = 1'b1;
      spq_pkg::REQ_POP_HEAD:  dec.is_head = 1'b1;
      spq_pkg::REQ_POP_EXACT: dec.exact   = 1'b1;
      default:                dec.exact   = 1'b0;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'(spq_pkg::FqDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= dec;
    end
  end

endmodule

FILE: hw/rtl/spq_back.sv
// ----------------------------------------------------------------------------
// spq_back
// Sorted row of entry cells; one command per cycle while the result is taken, registered result.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_back #(
  parameter int unsigned Depth = spq_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  spq_pkg::cmd_t      cmd_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output spq_pkg::rsp_t      rsp_o
);

  localparam int unsigned FillW = $clog2(Depth + 1);

  logic [15:0]      cell_q [Depth];
  logic [15:0]      cell_d [Depth];
  logic [FillW-1:0] fill_q, fill_d;
  logic [Depth-1:0] valid, ge, gt, sel, ins_bef, rem_bef;
  logic             hit, full, go;
  logic [15:0]      hit_word;
  logic             rsp_valid_q;
  spq_pkg::rsp_t    rsp_q, rsp_d;

  assign cmd_ready_o = !rsp_valid_q || rsp_ready_i;
  assign go          = cmd_valid_i && cmd_ready_o;
  assign full        = (fill_q == FillW'(Depth));

  // Per-cell compare; first-match found by a prefix over the cell flags.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      valid[i] = (FillW'(i) < fill_q);
      ge[i]    = valid[i] && (cell_q[i][15:8] >= cmd_i.key);
      gt[i]    = valid[i] && (cell_q[i][15:8] >  cmd_i.key);
    end
    // Cell i lies at/after the insert point if it or any earlier cell is > key.
    ins_bef[0] = gt[0];
    rem_bef[0] = cmd_i.is_head ? valid[0] : ge[0];
    for (int i = 1; i < Depth; i++) begin
      ins_bef[i] = ins_bef[i-1] || gt[i];
      rem_bef[i] = rem_bef[i-1] || (cmd_i.is_head ? 1'b0 : ge[i]);
    end
    sel[0] = rem_bef[0];
    for (int i = 1; i < Depth; i++) begin
      sel[i] = rem_bef[i] && !rem_bef[i-1];
    end
    hit_word = '0;
    for (int i = 0; i < Depth; i++) begin
      if (sel[i]) hit_word = cell_q[i];
    end
    hit = |sel && (!cmd_i.exact || hit_word[15:8] == cmd_i.key);
  end

  always_comb begin
    fill_d = fill_q;
    for (int i = 0; i < Depth; i++) cell_d[i] = cell_q[i];
    rsp_d = '0;
    if (cmd_i.is_push) begin
      if (full) begin
        rsp_d.full_reject = 1'b1;
      end else begin
        // Shift cells at/after the insert point up by one; load the gap.
        for (int i = 0; i < Depth; i++) begin
          if (ins_bef[i] || !valid[i]) begin
            if (i == 0) begin
              cell_d[i] = {cmd_i.key, cmd_i.msg};
            end else if (ins_bef[i-1] || (!valid[i-1])) begin
              cell_d[i] = cell_q[i-1];
            end else begin
              cell_d[i] = {cmd_i.key, cmd_i.msg};
            end
          end
        end
        fill_d = fill_q + FillW'(1);
        rsp_d.done_res = 1'b1;
      end
    end else if (hit) begin
      // Close the gap: cells at/after the removed one take their successor.
      for (int i = 0; i + 1 < Depth; i++) begin
        if (rem_bef[i]) cell_d[i] = cell_q[i+1];
      end
      fill_d = fill_q - FillW'(1);
      rsp_d.done_res     = 1'b1;
      rsp_d.out_message  = hit_word[7:0];
      rsp_d.out_priority = hit_word[15:8];
    end
    rsp_d.entry_count = spq_pkg::CountW'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (go) fill_q <= fill_d;
      if (go) rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rsp_q <= rsp_d;
      for (int i = 0; i < Depth; i++) cell_q[i] <= cell_d[i];
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `SPQ_ASSERT(a_fill_le_depth, clk_i, rst_ni, fill_q <= FillW'(Depth))
  `SPQ_ASSERT(a_fill_step, clk_i, rst_ni,
    go |=> (fill_q == $past(fill_q) || fill_q == $past(fill_q) + FillW'(1) ||
            fill_q == $past(fill_q) - FillW'(1)))
  `SPQ_ASSERT(a_hold_no_go, clk_i, rst_ni, !go |=> $stable(fill_q))
  `SPQ_ASSERT(a_sel_onehot, clk_i, rst_ni, cmd_valid_i |-> $onehot0(sel))
  `SPQ_ASSERT(a_stall_hold, clk_i, rst_ni, rsp_valid_q && !rsp_ready_i |=> $stable(rsp_q))

endmodule

FILE: hw/rtl/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded priority queue kept sorted by priority, with push and three pops.
// ----------------------------------------------------------------------------
// Usage:
//   req  channel: one beat per request (req_type, priority_key, item_message).
//   rsp  channel: one beat per request, in order (done_res, full_reject,
//                 out_message, out_priority, entry_count).
//   A front stage decodes requests into a two-entry command FIFO; the back
//   stage holds the entries in a row of cells that compare against the key
//   in parallel and shift up or down by one.
//   Path: request beat, command FIFO entry, result register, result beat.
//   Throughput: one request per cycle while the receiver takes results.
//   Reset: the queue is emptied (fill count zero), both channels go idle;
//   cell contents are not cleared and are never read before written.
//   Receiver stall: the result register holds, the back stops taking
//   commands, the FIFO fills, then req.ready drops.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefaultDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  logic          cmd_valid, cmd_ready;
  spq_pkg::cmd_t cmd;

  // Accept and classify.
  spq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .in_req_i   (req.payload),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // Execute against the sorted cell row.
  spq_back #(.Depth(QUEUE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .rsp_valid_o(rsp.valid),
    .rsp_ready_i(rsp.ready),
    .rsp_o      (rsp.payload)
  );

endmodule

FILE: tb/spq_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_tb_pkg
// Shared sizes and limits of the sorted priority queue testbench.
// ----------------------------------------------------------------------------
package spq_tb_pkg;

  localparam int unsigned QueueDepth = spq_pkg::DefaultDepth;
  localparam int unsigned RandItems  = 900;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned HoldOff    = 300;

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks sorted_priority_queue_unit: pushes and the three pops are sent over
// the request channel, and each result beat is compared field by field with
// a local sorted-list model of the queue.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  logic clk_i;
  logic rst_ni;

  spq_req_if req ();
  spq_rsp_if rsp ();

  sorted_priority_queue_unit #(.QUEUE_DEPTH(QueueDepth)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  // Model state: entries kept sorted, priority in the upper byte.
  logic [15:0] model_entries[$];
  rsp_t        pending_rsp[$];

  int  err_count;
  int  sent_count;
  int  rsp_count;
  int  idle_cycles;
  bit  hold_rsp;
  int  push_hits, pop_hits, full_hits, miss_hits;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Work out the result of one request and update the model queue.
  function automatic rsp_t queue_apply(req_t r);
    rsp_t res;
    int   pos;
    bit   hit;
    res = '0;
    hit = 1'b0;
    pos = 0;
    if (req_e'(r.req_type) == REQ_PUSH) begin
      if (model_entries.size() >= QueueDepth) begin
        res.full_reject = 1'b1;
        full_hits++;
      end else begin
        // Place after every entry of equal priority.
        while (pos < model_entries.size() && model_entries[pos][15:8] <= r.priority_key)
          pos++;
        model_entries.insert(pos, {r.priority_key, r.item_message});
        res.done_res = 1'b1;
        push_hits++;
      end
    end else begin
      if (req_e'(r.req_type) == REQ_POP_HEAD) begin
        hit = model_entries.size() > 0;
      end else begin
        while (pos < model_entries.size() && model_entries[pos][15:8] < r.priority_key)
          pos++;
        hit = pos < model_entries.size();
        // Exact pop looks only at the first entry at or above the key.
        if (hit && req_e'(r.req_type) == REQ_POP_EXACT &&
            model_entries[pos][15:8] != r.priority_key)
          hit = 1'b0;
      end
      if (hit) begin
        res.done_res     = 1'b1;
        res.out_priority = model_entries[pos][15:8];
        res.out_message  = model_entries[pos][7:0];
        model_entries.delete(pos);
        pop_hits++;
      end else begin
        miss_hits++;
      end
    end
    res.entry_count = 5'(model_entries.size());
    return res;
  endfunction

  // Send one request beat after a random gap; predict on acceptance.
  // Valid stays up after the beat so a following send can go back to back.
  task automatic send_req(req_e op, logic [7:0] key, logic [7:0] msg, bit no_gap = 0);
    req_t r;
    int   gap;
    r.req_type     = op;
    r.priority_key = key;
    r.item_message = msg;
    gap = no_gap ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                    : $urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.payload <= r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp.push_back(queue_apply(r));
    sent_count++;
  endtask

  // Drop valid after the last beat of a burst.
  task automatic idle_req();
    req.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drive result ready: low while hold_rsp is set, and low now and then at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_rsp) begin
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp.valid && rsp.ready) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        $error("result beat with no expectation: %p", rsp.payload);
        err_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.payload.done_res !== exp_rsp.done_res) begin
          $error("done_res exp %0d got %0d", exp_rsp.done_res, rsp.payload.done_res);
          err_count++;
        end
        if (rsp.payload.full_reject !== exp_rsp.full_reject) begin
          $error("full_reject exp %0d got %0d", exp_rsp.full_reject,
                 rsp.payload.full_reject);
          err_count++;
        end
        if (rsp.payload.out_message !== exp_rsp.out_message) begin
          $error("out_message exp %0h got %0h", exp_rsp.out_message,
                 rsp.payload.out_message);
          err_count++;
        end
        if (rsp.payload.out_priority !== exp_rsp.out_priority) begin
          $error("out_priority exp %0h got %0h", exp_rsp.out_priority,
                 rsp.payload.out_priority);
          err_count++;
        end
        if (rsp.payload.entry_count !== exp_rsp.entry_count) begin
          $error("entry_count exp %0d got %0d", exp_rsp.entry_count,
                 rsp.payload.entry_count);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Extremes of every field, each operation, misses on an empty queue and an exact-key miss.
  task automatic test_directed();
    send_req(REQ_POP_HEAD, 8'h00, 8'h00);
    send_req(REQ_POP_EXACT, 8'hff, 8'hff);
    send_req(REQ_POP_GE, 8'h00, 8'h00);
    send_req(REQ_PUSH, 8'h80, 8'h11);
    send_req(REQ_PUSH, 8'h80, 8'h22);
    send_req(REQ_PUSH, 8'h00, 8'hff);
    send_req(REQ_PUSH, 8'hff, 8'h00);
    send_req(REQ_PUSH, 8'h40, 8'haa);
    send_req(REQ_POP_EXACT, 8'h7f, 8'h55);
    send_req(REQ_POP_EXACT, 8'h80, 8'h00);
    send_req(REQ_POP_GE, 8'h81, 8'h00);
    send_req(REQ_POP_GE, 8'h41, 8'h00);
    send_req(REQ_POP_HEAD, 8'h00, 8'h00);
    send_req(REQ_POP_HEAD, 8'h00, 8'h00);
    send_req(REQ_POP_HEAD, 8'h00, 8'h00);
    send_req(REQ_POP_GE, 8'hff, 8'h00);
    idle_req();
  endtask

  // Push past capacity, with results held back at the start, then drain.
  task automatic test_full_and_stall();
    hold_rsp = 1'b1;
    fork
      begin
        repeat (HoldOff) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      begin
        for (int i = 0; i < QueueDepth + 3; i++)
          send_req(REQ_PUSH, 8'($urandom_range(0, 7)), 8'($urandom), 1'b1);
        idle_req();
      end
    join
    for (int i = 0; i < QueueDepth + 1; i++)
      send_req(REQ_POP_HEAD, 8'($urandom), 8'($urandom));
    idle_req();
  endtask

  // Random mix: pushes weighted by fill level, keys drawn from a few values
  // so exact pops often hit, with full-range keys now and then.
  task automatic test_random();
    req_e       op;
    logic [7:0] key;
    int         pick;
    for (int i = 0; i < RandItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < ((model_entries.size() > 12) ? 30 : 55)) op = REQ_PUSH;
      else if (pick < 70) op = REQ_POP_HEAD;
      else if (pick < 85) op = REQ_POP_EXACT;
      else op = REQ_POP_GE;
      key = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7) * 36);
      send_req(op, key, 8'($urandom), ($urandom_range(0, 4) == 0));
    end
    idle_req();
  endtask

  initial begin
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.payload = '0;
    err_count = 0; sent_count = 0; rsp_count = 0;
    hold_rsp = 1'b0;
    push_hits = 0; pop_hits = 0; full_hits = 0; miss_hits = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_and_stall();
    test_random();

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d requests, checked %0d results", sent_count, rsp_count);
    $display("pushes %0d, pops %0d, full rejects %0d, misses %0d",
             push_hits, pop_hits, full_hits, miss_hits);
    if (err_count == 0 && pending_rsp.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_front.sv
hw/rtl/spq_back.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/spq_tb_pkg.sv
tb/testbench.sv
